FILE: hdl/tsh32_pkg.sv
// Package for the table string hash unit: constants, register indexes,
// the nibble table and the shared structure types. No dependencies.
`default_nettype none

package tsh32_pkg;

  localparam int unsigned HashW   = 32;
  localparam int unsigned CharW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 32;

  localparam logic [CfgIdxW-1:0] CfgRawMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSeed    = 2'd1;

  localparam logic [HashW-1:0] DefaultSeed = 32'h7FED7FED;
  localparam logic [HashW-1:0] OffsetInit  = 32'hEEEEEEEE;
  localparam logic [HashW-1:0] OffsetBias  = 32'h00000003;
  localparam logic [HashW-1:0] HashOne     = 32'h00000001;

  localparam logic [CharW-1:0] CharNul       = 8'h00;
  localparam logic [CharW-1:0] CharLowerA    = 8'h61;
  localparam logic [CharW-1:0] CharLowerZ    = 8'h7A;
  localparam logic [CharW-1:0] CaseDelta     = 8'h20;
  localparam logic [CharW-1:0] CharSlash     = 8'h2F;
  localparam logic [CharW-1:0] CharBackslash = 8'h5C;

  typedef struct packed {
    logic [HashW-1:0] hash;
    logic [HashW-1:0] offset;
    logic             at_start;
  } state_t;

  typedef struct packed {
    logic             raw_mode;
    logic [HashW-1:0] seed;
  } cfg_t;

  function automatic logic [HashW-1:0] nib_word(input logic [3:0] idx);
    logic [HashW-1:0] w;
    case (idx)
      4'h0:    w = 32'h486E26EE;
      4'h1:    w = 32'hDCAA16B3;
      4'h2:    w = 32'hE1918EEF;
      4'h3:    w = 32'h202DAFDB;
      4'h4:    w = 32'h341C7DC7;
      4'h5:    w = 32'h1C365303;
      4'h6:    w = 32'h40EF2D37;
      4'h7:    w = 32'h65FD5E49;
      4'h8:    w = 32'hD6057177;
      4'h9:    w = 32'h904ECE93;
      4'hA:    w = 32'h1C38024F;
      4'hB:    w = 32'h98FD323B;
      4'hC:    w = 32'hE3061AE7;
      4'hD:    w = 32'hA39B0FA1;
      4'hE:    w = 32'h9797F25F;
      4'hF:    w = 32'hE4444563;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/table_string_hash_32_unit.sv
// Top level of the table string hash unit: input register, state update,
// result register. Depends on tsh32_pkg, tsh32_cfg and tsh32_step.
//
//   Channel   Direction  Handshake                Payload
//   in        request    in_valid_i / in_ready_o   char_code_i
//   out       result     out_valid_o / out_ready_i hash_value_o
//   cfg       write      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A character is taken into the input register and processed from there, so one
// character per cycle is sustained while the input does not stall. A terminator's
// hash is written from the input register into the result register.
// Reset clears the state to the start of a string and empties both registers.
// A terminator held while the result register is still full stalls the input.
`default_nettype none

module table_string_hash_32_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [tsh32_pkg::CharW-1:0]   char_code_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [tsh32_pkg::HashW-1:0]        hash_value_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [tsh32_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [tsh32_pkg::CfgDatW-1:0] cfg_data_i
);

  tsh32_pkg::cfg_t             cfg;
  tsh32_pkg::state_t           state_q, state_d;
  logic                        s1_valid_q;
  logic [tsh32_pkg::CharW-1:0] s1_char_q;
  logic                        out_valid_q;
  logic [tsh32_pkg::HashW-1:0] out_hash_q;
  logic                        term;
  logic [tsh32_pkg::HashW-1:0] result;
  logic                        s2_go;
  logic                        in_take;

  assign cfg_ready_o = 1'b1;

  tsh32_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  tsh32_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg),
    .char_i   (s1_char_q),
    .state_o  (state_d),
    .term_o   (term),
    .result_o (result)
  );

  assign s2_go      = s1_valid_q && (!term || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s2_go;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_char_q <= char_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.hash     <= '0;
      state_q.offset   <= tsh32_pkg::OffsetInit;
      state_q.at_start <= 1'b1;
    end else if (s2_go) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_go && term) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && term) begin
      out_hash_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_hash_q;

  a_hash_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hash_value_o != '0))
    else $error("result hash is zero");

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_go && term) |=> (state_q.at_start && out_valid_q))
    else $error("terminator did not rearm or load a result");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_go) |=> (s1_valid_q && $stable(s1_char_q)))
    else $error("held character was lost or changed");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(s2_go && term))
    else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

FILE: hdl/tsh32_cfg.sv
// Configuration registers of the table string hash unit (raw mode, seed).
// Depends on tsh32_pkg.
`default_nettype none

module tsh32_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         wr_en_i,
  input  wire logic [tsh32_pkg::CfgIdxW-1:0] wr_index_i,
  input  wire logic [tsh32_pkg::CfgDatW-1:0] wr_data_i,
  output tsh32_pkg::cfg_t                   cfg_o
);

  logic                          raw_mode_q;
  logic [tsh32_pkg::HashW-1:0]   seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_mode_q <= 1'b0;
      seed_q     <= '0;
    end else if (wr_en_i) begin
      case (wr_index_i)
        tsh32_pkg::CfgRawMode: raw_mode_q <= wr_data_i[0];
        tsh32_pkg::CfgSeed:    seed_q     <= wr_data_i[tsh32_pkg::HashW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.raw_mode = raw_mode_q;
  assign cfg_o.seed     = seed_q;

endmodule

`default_nettype wire

FILE: hdl/tsh32_step.sv
// Combinational update of the running hash and offset for one character.
// Depends on tsh32_pkg.
`default_nettype none

module tsh32_step (
  input  wire tsh32_pkg::state_t           state_i,
  input  wire tsh32_pkg::cfg_t             cfg_i,
  input  wire logic [tsh32_pkg::CharW-1:0] char_i,
  output tsh32_pkg::state_t                state_o,
  output logic                             term_o,
  output logic [tsh32_pkg::HashW-1:0]      result_o
);

  logic [tsh32_pkg::HashW-1:0] hash_start;
  logic [tsh32_pkg::HashW-1:0] off_start;
  logic [tsh32_pkg::CharW-1:0] folded;
  logic [tsh32_pkg::HashW-1:0] hash_sum;
  logic [tsh32_pkg::HashW-1:0] nib_diff;
  logic [tsh32_pkg::HashW-1:0] hash_new;
  logic [tsh32_pkg::HashW-1:0] off_new;

  always_comb begin
    if (state_i.at_start) begin
      hash_start = (cfg_i.seed != '0) ? cfg_i.seed : tsh32_pkg::DefaultSeed;
      off_start  = tsh32_pkg::OffsetInit;
    end else begin
      hash_start = state_i.hash;
      off_start  = state_i.offset;
    end

    folded = char_i;
    if (!cfg_i.raw_mode) begin
      if (char_i inside {[tsh32_pkg::CharLowerA:tsh32_pkg::CharLowerZ]}) begin
        folded = char_i - tsh32_pkg::CaseDelta;
      end else if (char_i == tsh32_pkg::CharSlash) begin
        folded = tsh32_pkg::CharBackslash;
      end
    end

    hash_sum = hash_start + off_start;
    nib_diff = tsh32_pkg::nib_word(folded[7:4]) - tsh32_pkg::nib_word(folded[3:0]);
    hash_new = hash_sum ^ nib_diff;
    off_new  = (off_start << 5) + off_start
             + {{(tsh32_pkg::HashW-tsh32_pkg::CharW){1'b0}}, folded}
             + hash_new + tsh32_pkg::OffsetBias;

    term_o   = (char_i == tsh32_pkg::CharNul);
    result_o = (hash_start != '0) ? hash_start : tsh32_pkg::HashOne;

    if (term_o) begin
      state_o.hash     = hash_start;
      state_o.offset   = off_start;
      state_o.at_start = 1'b1;
    end else begin
      state_o.hash     = hash_new;
      state_o.offset   = off_new;
      state_o.at_start = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: dv/table_string_hash_32_unit_test.sv
// Self-checking testbench for table_string_hash_32_unit: drives strings of characters
// and register writes, predicts every string hash and compares each result in order.
// Depends on tsh32_pkg and the RTL of the unit only.
`default_nettype none

module table_string_hash_32_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned RandomChars  = 280;
  localparam logic [tsh32_pkg::HashW-1:0] OffsetMult = 32'd33;
  localparam logic [tsh32_pkg::CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [tsh32_pkg::CfgIdxW-1:0] CfgSpareB = 2'd3;
  localparam logic [tsh32_pkg::HashW-1:0] NibbleWords [16] = '{
    32'h486E26EE, 32'hDCAA16B3, 32'hE1918EEF, 32'h202DAFDB,
    32'h341C7DC7, 32'h1C365303, 32'h40EF2D37, 32'h65FD5E49,
    32'hD6057177, 32'h904ECE93, 32'h1C38024F, 32'h98FD323B,
    32'hE3061AE7, 32'hA39B0FA1, 32'h9797F25F, 32'hE4444563
  };

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic [tsh32_pkg::CharW-1:0]       char_code_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic [tsh32_pkg::HashW-1:0]       hash_value_o;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [tsh32_pkg::CfgIdxW-1:0]     cfg_index_i = '0;
  logic [tsh32_pkg::CfgDatW-1:0]     cfg_data_i = '0;

  logic [tsh32_pkg::HashW-1:0] model_hash;
  logic [tsh32_pkg::HashW-1:0] model_offset;
  logic                        model_at_start;
  logic                        model_raw_mode;
  logic [tsh32_pkg::HashW-1:0] model_seed;
  logic [tsh32_pkg::HashW-1:0] pending_hashes [$];

  int unsigned mismatches = 0;
  int unsigned chars_sent = 0;
  int unsigned stall_cycles = 0;
  int unsigned rx_hold_cycles = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;

  table_string_hash_32_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic hash_char(input logic [tsh32_pkg::CharW-1:0] c);
    logic [tsh32_pkg::CharW-1:0] folded;
    if (model_at_start) begin
      model_hash     = (model_seed != '0) ? model_seed : tsh32_pkg::DefaultSeed;
      model_offset   = tsh32_pkg::OffsetInit;
      model_at_start = 1'b0;
    end
    if (c == tsh32_pkg::CharNul) begin
      pending_hashes.push_back((model_hash != '0) ? model_hash : tsh32_pkg::HashOne);
      model_at_start = 1'b1;
    end else begin
      folded = c;
      if (!model_raw_mode) begin
        if (c >= tsh32_pkg::CharLowerA && c <= tsh32_pkg::CharLowerZ) begin
          folded = c - tsh32_pkg::CaseDelta;
        end else if (c == tsh32_pkg::CharSlash) begin
          folded = tsh32_pkg::CharBackslash;
        end
      end
      model_hash   = model_hash + model_offset;
      model_offset = model_offset * OffsetMult;
      model_hash   = model_hash ^ (NibbleWords[folded[7:4]] - NibbleWords[folded[3:0]]);
      model_offset = model_offset
                   + {{(tsh32_pkg::HashW-tsh32_pkg::CharW){1'b0}}, folded}
                   + model_hash + tsh32_pkg::OffsetBias;
    end
  endtask

  task automatic send_char(input logic [tsh32_pkg::CharW-1:0] c);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    hash_char(c);
    chars_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tsh32_pkg::CfgIdxW-1:0] idx,
                           input logic [tsh32_pkg::CfgDatW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      tsh32_pkg::CfgRawMode: model_raw_mode = data[0];
      tsh32_pkg::CfgSeed:    model_seed = data;
      default:               ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [tsh32_pkg::CharW-1:0] pick_char();
    case ($urandom_range(0, 5))
      0:       return tsh32_pkg::CharLowerA + tsh32_pkg::CharW'($urandom_range(0, 25));
      1:       return tsh32_pkg::CharSlash;
      2:       return tsh32_pkg::CharLowerA - tsh32_pkg::CaseDelta
                      + tsh32_pkg::CharW'($urandom_range(0, 25));
      3:       return tsh32_pkg::CharW'($urandom_range(128, 255));
      default: return tsh32_pkg::CharW'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_string(input int unsigned len);
    repeat (len) send_char(pick_char());
    send_char(tsh32_pkg::CharNul);
  endtask

  task automatic test_defaults();
    send_char(tsh32_pkg::CharNul);
    send_char(tsh32_pkg::CharLowerA);
    send_char(tsh32_pkg::CharSlash);
    send_char(tsh32_pkg::CharNul);
  endtask

  task automatic test_folding_and_extremes();
    logic [tsh32_pkg::CharW-1:0] chars [10] = '{8'h61, 8'h7A, 8'h41, 8'h5A, 8'h2F,
                                                 8'h5C, 8'h01, 8'h7F, 8'h80, 8'hFF};
    foreach (chars[i]) send_char(chars[i]);
    send_char(tsh32_pkg::CharNul);
    wait_idle();
    write_reg(tsh32_pkg::CfgRawMode, 32'd1);
    foreach (chars[i]) send_char(chars[i]);
    send_char(tsh32_pkg::CharNul);
  endtask

  task automatic test_seed_extremes();
    wait_idle();
    write_reg(tsh32_pkg::CfgSeed, 32'hFFFFFFFF);
    send_char(tsh32_pkg::CharNul);
    send_char(8'hFF);
    send_char(tsh32_pkg::CharNul);
    wait_idle();
    write_reg(tsh32_pkg::CfgSeed, 32'h00000001);
    send_char(tsh32_pkg::CharNul);
  endtask

  // The seed is chosen so that the first character brings the hash to zero, which
  // must come out as one.
  task automatic test_zero_hash();
    logic [tsh32_pkg::CharW-1:0] c;
    c = 8'h41;
    wait_idle();
    write_reg(tsh32_pkg::CfgSeed,
              (NibbleWords[c[7:4]] - NibbleWords[c[3:0]]) - tsh32_pkg::OffsetInit);
    send_char(c);
    send_char(tsh32_pkg::CharNul);
  endtask

  task automatic test_mid_string_writes();
    wait_idle();
    write_reg(tsh32_pkg::CfgRawMode, 32'd0);
    write_reg(tsh32_pkg::CfgSeed, 32'h0BADF00D);
    send_char(8'h62);
    send_char(tsh32_pkg::CharSlash);
    wait_idle();
    write_reg(tsh32_pkg::CfgSeed, 32'h12345678);
    write_reg(tsh32_pkg::CfgRawMode, 32'd1);
    send_char(8'h62);
    send_char(tsh32_pkg::CharSlash);
    send_char(tsh32_pkg::CharNul);
    send_char(tsh32_pkg::CharNul);
  endtask

  task automatic test_spare_indexes();
    wait_idle();
    write_reg(CfgSpareA, 32'hFFFFFFFF);
    write_reg(CfgSpareB, 32'hA5A5A5A5);
    send_char(8'h71);
    send_char(tsh32_pkg::CharNul);
  endtask

  task automatic test_random_strings();
    int unsigned target;
    int unsigned phase;
    target = chars_sent + RandomChars;
    phase = 0;
    while (chars_sent < target) begin
      wait_idle();
      write_reg(tsh32_pkg::CfgRawMode, tsh32_pkg::CfgDatW'($urandom_range(0, 1)));
      case (phase % 4)
        0:       write_reg(tsh32_pkg::CfgSeed, '0);
        1:       write_reg(tsh32_pkg::CfgSeed, 32'hFFFFFFFF);
        default: write_reg(tsh32_pkg::CfgSeed, $urandom);
      endcase
      tx_gaps_on = (phase % 3) != 1;
      rx_gaps_on = (phase % 3) != 2;
      repeat (6) send_string($urandom_range(0, 12));
      if (phase == 2) begin
        wait_idle();
      end
      repeat (2) send_string($urandom_range(0, 12));
      phase++;
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    rx_hold_cycles = 200;
    repeat (30) send_string($urandom_range(0, 2));
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  initial begin : receiver
    int unsigned rx_wait;
    rx_wait = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles != 0) begin
        rx_wait = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (rx_wait != 0) begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i && rx_wait == 0) begin
        rx_wait = rx_gaps_on ? $urandom_range(0, 15) : 0;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    logic [tsh32_pkg::HashW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_hashes.size() == 0) begin
        $error("hash_value: no result expected, actual %h", hash_value_o);
        mismatches++;
      end else begin
        want = pending_hashes.pop_front();
        if (hash_value_o !== want) begin
          $error("hash_value: expected %h, actual %h", want, hash_value_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else if (++stall_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    model_hash     = '0;
    model_offset   = tsh32_pkg::OffsetInit;
    model_at_start = 1'b1;
    model_raw_mode = 1'b0;
    model_seed     = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_defaults();
    test_folding_and_extremes();
    test_seed_extremes();
    test_zero_hash();
    test_mid_string_writes();
    test_spare_indexes();
    test_random_strings();
    test_backpressure();
    wait_idle();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
